// ===== hdl/lpd_pkg.sv =====
package lpd_pkg;

	localparam int DEF_CHANNELS = 16;
	localparam int HDR_BYTES    = 4;
	localparam int HDR_CNT_W    = 3;
	localparam int LEN_W        = 32;
	localparam int CH_W         = 4;
	localparam int BYTE_W       = 8;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd65535;

	typedef enum logic [1:0] {
		OP_DATA      = 2'd0,
		OP_CLOSE     = 2'd1,
		OP_ERR_CLOSE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		KIND_PAYLOAD   = 3'd0,
		KIND_EMPTY     = 3'd1,
		KIND_CLOSE     = 3'd2,
		KIND_ERR_CLOSE = 3'd3,
		KIND_BAD_LEN   = 3'd4
	} kind_t;

	// While the header is being collected, word holds the length bytes seen so far.
	// Once a message is open, hdr_cnt is four and word counts the payload bytes still due.
	typedef struct packed {
		logic [HDR_CNT_W-1:0] hdr_cnt;
		logic [LEN_W-1:0]     word;
	} ctx_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              dropped;
	} res_t;

	localparam int CTX_W = $bits(ctx_t);

endpackage

// ===== hdl/length_prefix_deframer_core.sv =====
// Channel      Signals                                  Contents
// s_*          s_tvalid s_tready s_tdata s_tuser        one stream byte or close event
// m_*          m_tvalid m_tready m_tdata m_tuser m_tlast one result word
// cfg_*        cfg_write cfg_data                       largest message length
//
// A word is taken every cycle unless m_tready stalls; it passes stage s1, then the result
// register. Per-channel context sits in one RAM, read when the word is accepted, written
// as it leaves s1, with the last write forwarded to a following word of the same channel.
// After reset the context RAM is cleared entry by entry with s_tready low.
// A stalled m_tready holds the result register and then the stage behind it.
module length_prefix_deframer_core import lpd_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // channel[3:0], data_byte[11:4], zero[15:12]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // channel_res[3:0], payload_byte[11:4], partial_dropped[12]
	output logic [2:0]  m_tuser,   // out_kind[2:0]
	output logic        m_tlast,
	input  logic        cfg_write,
	input  logic [31:0] cfg_data
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [LEN_W-1:0]  max_len_q;
	logic              clearing_q;
	logic [AW-1:0]     clr_q;

	logic              s1_valid;
	logic [1:0]        s1_opcode;
	logic [CH_W-1:0]   s1_ch;
	logic [BYTE_W-1:0] s1_byte;

	logic              fwd_valid_q;
	logic [CH_W-1:0]   fwd_ch_q;
	ctx_t              fwd_ctx_q;

	logic              out_valid_q;
	kind_t             out_kind_q;
	logic [CH_W-1:0]   out_ch_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic              out_dropped_q;

	logic              accept;
	logic              step;
	logic              ch_ok;
	logic [CTX_W-1:0]  ram_rdata;
	ctx_t              ctx_cur;
	ctx_t              ctx_next;
	logic              emit;
	res_t              res;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CTX_W-1:0]  ram_wdata;

	assign step     = s1_valid && (!out_valid_q || m_tready);
	assign s_tready = !clearing_q && (!s1_valid || step);
	assign accept   = s_tvalid && s_tready;
	assign ch_ok    = (32'(s1_ch) < 32'(CHANNELS));
	assign ctx_cur  = (fwd_valid_q && fwd_ch_q == s1_ch) ? fwd_ctx_q : ctx_t'(ram_rdata);

	assign ram_we    = clearing_q || (step && ch_ok);
	assign ram_waddr = clearing_q ? clr_q : AW'(s1_ch);
	assign ram_wdata = clearing_q ? CTX_W'(0) : CTX_W'(ctx_next);

	lpd_ram #(
		.WIDTH(CTX_W),
		.DEPTH(CHANNELS)
	) u_ctx_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(AW'(s_tdata[CH_W-1:0])),
		.rdata(ram_rdata)
	);

	lpd_ctx_update u_update (
		.opcode   (s1_opcode),
		.data_byte(s1_byte),
		.ctx      (ctx_cur),
		.max_len  (max_len_q),
		.ctx_next (ctx_next),
		.emit     (emit),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q   <= MAX_LEN_RESET;
			clearing_q  <= 1'b1;
			clr_q       <= '0;
			s1_valid    <= 1'b0;
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				max_len_q <= cfg_data;
			end
			if (clearing_q) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == AW'(CHANNELS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (step) begin
				s1_valid <= 1'b0;
			end
			if (clearing_q) begin
				fwd_valid_q <= 1'b0;
			end else if (step && ch_ok) begin
				fwd_valid_q <= 1'b1;
			end
			if (step) begin
				out_valid_q <= emit && ch_ok;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_opcode <= s_tuser;
			s1_ch     <= s_tdata[CH_W-1:0];
			s1_byte   <= s_tdata[CH_W+BYTE_W-1:CH_W];
		end
		if (step && ch_ok) begin
			fwd_ch_q  <= s1_ch;
			fwd_ctx_q <= ctx_next;
		end
		if (step && emit) begin
			out_kind_q    <= res.kind;
			out_ch_q      <= s1_ch;
			out_byte_q    <= res.data;
			out_last_q    <= res.last;
			out_dropped_q <= res.dropped;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_dropped_q, out_byte_q, out_ch_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== hdl/lpd_ram.sv =====
module lpd_ram import lpd_pkg::*; #(
	parameter int WIDTH = CTX_W,
	parameter int DEPTH = DEF_CHANNELS
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/lpd_ctx_update.sv =====
module lpd_ctx_update import lpd_pkg::*; (
	input  logic [1:0]        opcode,
	input  logic [BYTE_W-1:0] data_byte,
	input  ctx_t              ctx,
	input  logic [LEN_W-1:0]  max_len,
	output ctx_t              ctx_next,
	output logic              emit,
	output res_t              res
);

	logic [LEN_W-1:0] len;

	assign len = {ctx.word[LEN_W-BYTE_W-1:0], data_byte};

	always_comb begin
		ctx_next    = ctx;
		emit        = 1'b0;
		res.kind    = KIND_PAYLOAD;
		res.data    = '0;
		res.last    = 1'b0;
		res.dropped = 1'b0;
		unique case (op_t'(opcode))
			OP_DATA: begin
				if (ctx.hdr_cnt < HDR_CNT_W'(HDR_BYTES)) begin
					ctx_next.hdr_cnt = ctx.hdr_cnt + HDR_CNT_W'(1);
					if (ctx.hdr_cnt == '0) begin
						ctx_next.word = LEN_W'(data_byte);
					end else begin
						ctx_next.word = len;
					end
					if (ctx.hdr_cnt == HDR_CNT_W'(HDR_BYTES - 1)) begin
						if (len < LEN_W'(HDR_BYTES) || len > max_len) begin
							ctx_next = '0;
							emit     = 1'b1;
							res.kind = KIND_BAD_LEN;
						end else if (len == LEN_W'(HDR_BYTES)) begin
							ctx_next = '0;
							emit     = 1'b1;
							res.kind = KIND_EMPTY;
						end else begin
							ctx_next.word = len - LEN_W'(HDR_BYTES);
						end
					end
				end else begin
					emit     = 1'b1;
					res.data = data_byte;
					if (ctx.word == LEN_W'(1)) begin
						res.last = 1'b1;
						ctx_next = '0;
					end else begin
						ctx_next.word = ctx.word - LEN_W'(1);
					end
				end
			end
			OP_CLOSE, OP_ERR_CLOSE: begin
				ctx_next    = '0;
				emit        = 1'b1;
				res.kind    = (op_t'(opcode) == OP_CLOSE) ? KIND_CLOSE : KIND_ERR_CLOSE;
				res.dropped = (ctx.hdr_cnt != '0);
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== tb/tb.sv =====
module tb import lpd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHANNELS = DEF_CHANNELS;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WORDS_PER_PHASE = 190;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] ch;
		logic [7:0] data;
	} in_word_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] ch;
		logic [7:0] data;
		logic       last;
		logic       dropped;
	} frame_res_t;

	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_MOSTLY,
		RDY_SPARSE,
		RDY_COIN
	} rdy_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'd0;
	logic [1:0]  s_tuser = 2'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_write = 1'b0;
	logic [31:0] cfg_data = 32'd0;

	in_word_t   pending_q[$];
	frame_res_t frame_res_q[$];

	logic [31:0] max_len = MAX_LEN_RESET;
	logic [2:0]  hdr_seen[CHANNELS];
	logic [31:0] len_acc[CHANNELS];
	logic [31:0] pay_seen[CHANNELS];

	logic [31:0] g_len[CHANNELS];
	int          g_pos[CHANNELS];
	int          g_total[CHANNELS];
	logic        g_close[CHANNELS];

	in_word_t  cur_word;
	int        gap_left = 0;
	int        burst_left = 0;
	rdy_mode_t rdy_mode = RDY_ALWAYS;
	int        mode_left = 0;
	logic [1:0] rdy_phase = 2'd0;

	int words_in = 0;
	int results_seen = 0;
	int err_cnt = 0;
	int n_settings = 1;

	length_prefix_deframer_core #(
		.CHANNELS(CHANNELS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_write(cfg_write),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	task automatic clear_ctx(input logic [3:0] ch);
		hdr_seen[ch] = 3'd0;
		len_acc[ch] = 32'd0;
		pay_seen[ch] = 32'd0;
	endtask

	task automatic push_res(input kind_t kind, input logic [3:0] ch, input logic [7:0] data,
			input logic last, input logic dropped);
		frame_res_t r;
		r.kind = kind;
		r.ch = ch;
		r.data = data;
		r.last = last;
		r.dropped = dropped;
		frame_res_q = {frame_res_q, r};
	endtask

	task automatic predict_deframe(input in_word_t w);
		logic dropped;
		logic [31:0] len;
		if (w.op == OP_CLOSE || w.op == OP_ERR_CLOSE) begin
			dropped = (hdr_seen[w.ch] != 3'd0 || pay_seen[w.ch] != 32'd0);
			clear_ctx(w.ch);
			push_res((w.op == OP_CLOSE) ? KIND_CLOSE : KIND_ERR_CLOSE, w.ch, 8'd0, 1'b0,
				dropped);
			return;
		end
		if (w.op != OP_DATA)
			return;
		if (hdr_seen[w.ch] < HDR_BYTES) begin
			if (hdr_seen[w.ch] == 3'd0)
				len_acc[w.ch] = {24'd0, w.data};
			else
				len_acc[w.ch] = {len_acc[w.ch][23:0], w.data};
			hdr_seen[w.ch] = hdr_seen[w.ch] + 3'd1;
			if (hdr_seen[w.ch] < HDR_BYTES)
				return;
			len = len_acc[w.ch];
			pay_seen[w.ch] = 32'd0;
			if (len < HDR_BYTES || len > max_len) begin
				clear_ctx(w.ch);
				push_res(KIND_BAD_LEN, w.ch, 8'd0, 1'b0, 1'b0);
			end else if (len == HDR_BYTES) begin
				clear_ctx(w.ch);
				push_res(KIND_EMPTY, w.ch, 8'd0, 1'b0, 1'b0);
			end
			return;
		end
		pay_seen[w.ch] = pay_seen[w.ch] + 32'd1;
		if (pay_seen[w.ch] >= len_acc[w.ch] - HDR_BYTES) begin
			clear_ctx(w.ch);
			push_res(KIND_PAYLOAD, w.ch, w.data, 1'b1, 1'b0);
		end else begin
			push_res(KIND_PAYLOAD, w.ch, w.data, 1'b0, 1'b0);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_deframe(cur_word);
				words_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0 || pending_q.size() == 0) begin
					if (gap_left != 0)
						gap_left--;
					s_tvalid <= 1'b0;
				end else begin
					cur_word = pending_q.pop_front();
					s_tdata <= {4'd0, cur_word.data, cur_word.ch};
					s_tuser <= cur_word.op;
					s_tvalid <= 1'b1;
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		frame_res_t got;
		frame_res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.kind = kind_t'(m_tuser);
				got.ch = m_tdata[3:0];
				got.data = m_tdata[11:4];
				got.last = m_tlast;
				got.dropped = m_tdata[12];
				results_seen++;
				if (frame_res_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected result: kind %0d ch %0d data %02h last %0b drop %0b",
							got.kind, got.ch, got.data, got.last, got.dropped);
				end else begin
					want = frame_res_q.pop_front();
					if (got.kind != want.kind || got.ch != want.ch || got.data != want.data ||
							got.last != want.last || got.dropped != want.dropped) begin
						err_cnt++;
						if (err_cnt <= 10) begin
							$display("mismatch: expected kind %0d ch %0d data %02h last %0b drop %0b",
								want.kind, want.ch, want.data, want.last, want.dropped);
							$display("          got kind %0d ch %0d data %02h last %0b drop %0b",
								got.kind, got.ch, got.data, got.last, got.dropped);
						end
					end
				end
			end
			if (mode_left == 0) begin
				rdy_mode = rdy_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(10, 80);
			end else begin
				mode_left--;
			end
			rdy_phase = rdy_phase + 2'd1;
			case (rdy_mode)
				RDY_ALWAYS: m_tready <= 1'b1;
				RDY_MOSTLY: m_tready <= ($urandom_range(0, 9) < 7);
				RDY_SPARSE: m_tready <= (rdy_phase == 2'd0);
				default:    m_tready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	task automatic add_word(input logic [1:0] op, input logic [3:0] ch, input logic [7:0] data);
		in_word_t w;
		w.op = op;
		w.ch = ch;
		w.data = data;
		pending_q = {pending_q, w};
	endtask

	function automatic logic [31:0] pick_len(input logic [31:0] lim);
		case ($urandom_range(0, 11))
			0: pick_len = 32'd4;
			1: pick_len = $urandom_range(0, 3);
			2: pick_len = lim;
			3: pick_len = (lim == 32'hFFFF_FFFF) ? lim : lim + 32'd1;
			4: pick_len = $urandom;
			default: pick_len = $urandom_range(5, (lim > 40 || lim < 5) ? 40 : lim);
		endcase
	endfunction

	task automatic fill_random(input int n_words);
		int made;
		int ch;
		int pick;
		logic [31:0] len;
		logic [7:0] b;
		made = 0;
		while (made < n_words) begin
			ch = $urandom_range(0, CHANNELS - 1);
			if (g_pos[ch] < g_total[ch] && $urandom_range(0, 99) < 2) begin
				g_total[ch] = g_pos[ch];
				g_close[ch] = 1'b1;
			end
			if (g_pos[ch] < g_total[ch]) begin
				if (g_pos[ch] < HDR_BYTES)
					b = 8'(g_len[ch] >> (8 * (3 - g_pos[ch])));
				else
					b = 8'($urandom);
				add_word(OP_DATA, 4'(ch), b);
				g_pos[ch]++;
				made++;
			end else if (g_close[ch]) begin
				add_word($urandom_range(0, 1) ? OP_CLOSE : OP_ERR_CLOSE, 4'(ch), 8'($urandom));
				g_close[ch] = 1'b0;
				made++;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					len = pick_len(max_len);
					g_len[ch] = len;
					g_pos[ch] = 0;
					if (len < HDR_BYTES || len > max_len) begin
						g_total[ch] = HDR_BYTES;
						g_close[ch] = 1'b0;
					end else if (len <= 52) begin
						g_total[ch] = len;
						g_close[ch] = ($urandom_range(0, 9) == 0);
					end else begin
						g_total[ch] = HDR_BYTES + $urandom_range(0, 20);
						g_close[ch] = 1'b1;
					end
				end else if (pick < 78) begin
					g_close[ch] = 1'b1;
				end else if (pick < 86) begin
					add_word(OP_DATA, 4'(ch), 8'($urandom));
					made++;
				end else if (pick < 92) begin
					add_word(OP_UNUSED, 4'(ch), 8'($urandom));
				end else begin
					g_len[ch] = $urandom;
					g_pos[ch] = 0;
					g_total[ch] = $urandom_range(1, 3);
					g_close[ch] = 1'b1;
				end
			end
		end
	endtask

	task automatic drain_idle();
		while (pending_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (frame_res_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [31:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_data <= value;
		max_len = value;
		@(posedge clk);
		cfg_write <= 1'b0;
		n_settings++;
	endtask

	initial begin
		logic [31:0] settings[8];
		settings = '{32'd4, 32'd0, 32'd3, 32'hFFFF_FFFF, 32'd200, 32'd12, 32'd5, 32'd65535};
		for (int i = 0; i < CHANNELS; i++) begin
			clear_ctx(4'(i));
			g_len[i] = 32'd0;
			g_pos[i] = 0;
			g_total[i] = 0;
			g_close[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		add_word(OP_DATA, 4'd0, 8'h00);
		add_word(OP_DATA, 4'd0, 8'h00);
		add_word(OP_DATA, 4'd0, 8'h00);
		add_word(OP_DATA, 4'd0, 8'h04);
		add_word(OP_DATA, 4'd15, 8'h00);
		add_word(OP_DATA, 4'd15, 8'h00);
		add_word(OP_DATA, 4'd15, 8'h00);
		add_word(OP_DATA, 4'd15, 8'h06);
		add_word(OP_DATA, 4'd15, 8'h00);
		add_word(OP_DATA, 4'd15, 8'hFF);
		add_word(OP_DATA, 4'd5, 8'h00);
		add_word(OP_DATA, 4'd5, 8'h00);
		add_word(OP_DATA, 4'd5, 8'h00);
		add_word(OP_DATA, 4'd5, 8'h03);
		add_word(OP_DATA, 4'd10, 8'hFF);
		add_word(OP_DATA, 4'd10, 8'hFF);
		add_word(OP_DATA, 4'd10, 8'hFF);
		add_word(OP_DATA, 4'd10, 8'hFF);
		add_word(OP_UNUSED, 4'd3, 8'hAA);
		add_word(OP_CLOSE, 4'd1, 8'h00);
		add_word(OP_DATA, 4'd2, 8'h00);
		add_word(OP_ERR_CLOSE, 4'd2, 8'h55);
		fill_random(WORDS_PER_PHASE);
		drain_idle();

		foreach (settings[i]) begin
			write_max_len(settings[i]);
			fill_random(WORDS_PER_PHASE);
			drain_idle();
		end

		if (frame_res_q.size() != 0) begin
			err_cnt++;
			$display("%0d expected results never arrived", frame_res_q.size());
		end
		$display("Accepted %0d words and checked %0d results over %0d length limits.",
			words_in, results_seen, n_settings);
		$display("Mismatches and unexpected results: %0d.", err_cnt);
		if (err_cnt == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Run did not finish in time.");
		$display("tb failed");
		$finish;
	end

endmodule
